// ===== src/line_splice_newline_normalizer_defines.svh =====
// Assertion macros for the line splice / newline normalizer.
// Bodies refer to clk and arst_n of the including module.
`ifndef LINE_SPLICE_NEWLINE_NORMALIZER_DEFINES_SVH
`define LINE_SPLICE_NEWLINE_NORMALIZER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Combinational invariant, checked at every edge out of reset.
`define LSNN_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Antecedent this cycle implies consequent on the next edge.
`define LSNN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LSNN_ASSERT(label, cond, msg)
`define LSNN_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== src/lsnn_pkg.sv =====
// Package for the line splice / newline normalizer.
// Character codes, lookahead kinds, action codes and the result record.
package lsnn_pkg;

	localparam int POS_WIDTH_DEF = 32;
	localparam int OUT_W         = 32;
	localparam int MAX_RES       = 3;
	localparam int FIFO_DEPTH    = 4;

	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_CR        = 8'h0d;
	localparam logic [7:0] CH_LF        = 8'h0a;

	typedef enum logic [1:0] {
		PEND_NONE,
		PEND_BS,
		PEND_BSCR,
		PEND_CR
	} pend_t;

	typedef enum logic [2:0] {
		ACT_PLAIN,
		ACT_CRLF,
		ACT_SPLICE2,
		ACT_SPLICE3,
		ACT_END
	} act_t;

	typedef struct packed {
		logic             last;
		logic             is_end;
		logic [OUT_W-1:0] column;
		logic [OUT_W-1:0] line_number;
		logic [OUT_W-1:0] byte_offset;
		logic [7:0]       char_value;
	} result_t;

endpackage

// ===== src/lsnn_decode.sv =====
// Per-byte decode: lookahead state machine and position update chain.
// Uses lsnn_pkg; purely combinational, registered by the top level.
module lsnn_decode import lsnn_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  pend_t                pend,
	input  logic [7:0]           byte_value,
	input  logic                 end_of_stream,
	input  logic [POS_WIDTH-1:0] off_i,
	input  logic [POS_WIDTH-1:0] line_i,
	input  logic [POS_WIDTH-1:0] col_i,
	output pend_t                pend_nxt,
	output logic [POS_WIDTH-1:0] off_nxt,
	output logic [POS_WIDTH-1:0] line_nxt,
	output logic [POS_WIDTH-1:0] col_nxt,
	output logic [1:0]           n_res,
	output result_t              res [MAX_RES]
);

	act_t                 act [MAX_RES];
	logic [7:0]           ach [MAX_RES];
	logic [1:0]           n_act;
	logic [POS_WIDTH-1:0] off_c  [MAX_RES+1];
	logic [POS_WIDTH-1:0] line_c [MAX_RES+1];
	logic [POS_WIDTH-1:0] col_c  [MAX_RES+1];
	logic                 exam_plain;

	// byte examined afresh with nothing pending emits itself
	assign exam_plain = (byte_value != CH_BACKSLASH) && (byte_value != CH_CR);

	// next lookahead kind
	always_comb begin
		pend_nxt = PEND_NONE;
		if (!end_of_stream) begin
			case (pend)
				PEND_BS: begin
					if (byte_value == CH_CR)
						pend_nxt = PEND_BSCR;
					else if (byte_value == CH_BACKSLASH)
						pend_nxt = PEND_BS;
					else if (byte_value != CH_LF)
						pend_nxt = PEND_NONE;
				end
				PEND_BSCR: begin
					if (byte_value == CH_BACKSLASH)
						pend_nxt = PEND_BS;
					else if (byte_value == CH_CR)
						pend_nxt = PEND_CR;
				end
				PEND_CR, PEND_NONE: begin
					if (byte_value == CH_BACKSLASH)
						pend_nxt = PEND_BS;
					else if (byte_value == CH_CR && !(pend == PEND_CR))
						pend_nxt = PEND_CR;
					else if (byte_value == CH_CR)
						pend_nxt = PEND_CR;
				end
				default: pend_nxt = PEND_NONE;
			endcase
		end
	end

	// action list for this byte
	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			act[i] = ACT_END;
			ach[i] = 8'h00;
		end
		n_act = 2'd0;
		if (end_of_stream) begin
			if (pend == PEND_BS || pend == PEND_BSCR) begin
				act[n_act] = ACT_PLAIN;
				ach[n_act] = CH_BACKSLASH;
				n_act      = n_act + 2'd1;
			end
			if (pend == PEND_BSCR || pend == PEND_CR) begin
				act[n_act] = ACT_PLAIN;
				ach[n_act] = CH_CR;
				n_act      = n_act + 2'd1;
			end
			act[n_act] = ACT_END;
			n_act      = n_act + 2'd1;
		end else begin
			case (pend)
				PEND_NONE: begin
					if (exam_plain) begin
						act[0] = ACT_PLAIN;
						ach[0] = byte_value;
						n_act  = 2'd1;
					end
				end
				PEND_BS: begin
					if (byte_value == CH_LF) begin
						act[0] = ACT_SPLICE2;
						n_act  = 2'd1;
					end else if (byte_value != CH_CR) begin
						act[0] = ACT_PLAIN;
						ach[0] = CH_BACKSLASH;
						n_act  = 2'd1;
						if (exam_plain) begin
							act[1] = ACT_PLAIN;
							ach[1] = byte_value;
							n_act  = 2'd2;
						end
					end
				end
				PEND_BSCR: begin
					if (byte_value == CH_LF) begin
						act[0] = ACT_SPLICE3;
						n_act  = 2'd1;
					end else begin
						act[0] = ACT_PLAIN;
						ach[0] = CH_BACKSLASH;
						act[1] = ACT_PLAIN;
						ach[1] = CH_CR;
						n_act  = 2'd2;
						if (exam_plain) begin
							act[2] = ACT_PLAIN;
							ach[2] = byte_value;
							n_act  = 2'd3;
						end
					end
				end
				PEND_CR: begin
					if (byte_value == CH_LF) begin
						act[0] = ACT_CRLF;
						ach[0] = CH_LF;
						n_act  = 2'd1;
					end else begin
						act[0] = ACT_PLAIN;
						ach[0] = CH_CR;
						n_act  = 2'd1;
						if (exam_plain) begin
							act[1] = ACT_PLAIN;
							ach[1] = byte_value;
							n_act  = 2'd2;
						end
					end
				end
				default: n_act = 2'd0;
			endcase
		end
	end

	// splices give no result; otherwise every action is a result
	assign n_res = (n_act != 2'd0 && (act[0] == ACT_SPLICE2 || act[0] == ACT_SPLICE3)) ?
		2'd0 : n_act;

	// position chain, one step per action
	always_comb begin
		off_c[0]  = off_i;
		line_c[0] = line_i;
		col_c[0]  = col_i;
		for (int i = 0; i < MAX_RES; i++) begin
			off_c[i+1]  = off_c[i];
			line_c[i+1] = line_c[i];
			col_c[i+1]  = col_c[i];
			if (2'(i) < n_act) begin
				case (act[i])
					ACT_PLAIN: begin
						off_c[i+1] = off_c[i] + POS_WIDTH'(1);
						if (ach[i] == CH_LF) begin
							line_c[i+1] = line_c[i] + POS_WIDTH'(1);
							col_c[i+1]  = '0;
						end else begin
							col_c[i+1] = col_c[i] + POS_WIDTH'(1);
						end
					end
					ACT_CRLF, ACT_SPLICE2: begin
						off_c[i+1]  = off_c[i] + POS_WIDTH'(2);
						line_c[i+1] = line_c[i] + POS_WIDTH'(1);
						col_c[i+1]  = '0;
					end
					ACT_SPLICE3: begin
						off_c[i+1]  = off_c[i] + POS_WIDTH'(3);
						line_c[i+1] = line_c[i] + POS_WIDTH'(1);
						col_c[i+1]  = '0;
					end
					default: ;
				endcase
			end
		end
	end

	assign off_nxt  = off_c[MAX_RES];
	assign line_nxt = line_c[MAX_RES];
	assign col_nxt  = col_c[MAX_RES];

	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			res[i].char_value  = (act[i] == ACT_END) ? 8'h00 : ach[i];
			res[i].is_end      = (act[i] == ACT_END);
			res[i].byte_offset = OUT_W'(off_c[i+1]);
			res[i].line_number = OUT_W'(line_c[i+1]);
			res[i].column      = OUT_W'(col_c[i+1]);
			res[i].last        = (2'(i) < n_res) && (2'(i) == n_res - 2'd1);
		end
	end

endmodule

// ===== src/line_splice_newline_normalizer.sv =====
// Top level of the line splice / newline normalizer: state registers and
// result queue. Depends on lsnn_pkg, lsnn_decode and the assertion header.
//
//  channel  | dir | tdata                              | tuser  | tlast
//  ---------+-----+------------------------------------+--------+-----------------
//  s_*      | in  | byte_value[7:0]                    | -      | end_of_stream
//  m_*      | out | char,offset,line,column (low->up)  | is_end | last of the item
//
// One input byte per cycle is taken while at most one result is queued.
// Each byte is decoded in the cycle it is accepted and its 0..3 results land
// in a four-entry result queue; results leave one per cycle while m_tready is
// high, so a byte giving two or three results stops input until one remains.
// A stalled m_tready backs up the queue and then s_tready drops.
// arst_n clears the lookahead kind, the position counters and the queue.
`include "line_splice_newline_normalizer_defines.svh"
module line_splice_newline_normalizer import lsnn_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] byte_value
	input  logic         s_tlast,   // end_of_stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // [7:0] char_value, [39:8] byte_offset,
	                                // [71:40] line_number, [103:72] column
	output logic         m_tuser,   // [0] is_end
	output logic         m_tlast    // last result of this transaction's byte
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	// stream state
	pend_t                pend_q;
	logic [POS_WIDTH-1:0] off_q;
	logic [POS_WIDTH-1:0] line_q;
	logic [POS_WIDTH-1:0] col_q;

	// decoder results
	pend_t                pend_nxt;
	logic [POS_WIDTH-1:0] off_nxt;
	logic [POS_WIDTH-1:0] line_nxt;
	logic [POS_WIDTH-1:0] col_nxt;
	logic [1:0]           n_res;
	result_t              res [MAX_RES];

	// result queue
	result_t              fifo_q [FIFO_DEPTH];
	logic [PW-1:0]        rd_q;
	logic [PW-1:0]        wr_q;
	logic [CW-1:0]        cnt_q;
	logic                 acc;
	logic                 pop;
	result_t              head;

	lsnn_decode #(
		.POS_WIDTH(POS_WIDTH)
	) u_decode (
		.pend         (pend_q),
		.byte_value   (s_tdata),
		.end_of_stream(s_tlast),
		.off_i        (off_q),
		.line_i       (line_q),
		.col_i        (col_q),
		.pend_nxt     (pend_nxt),
		.off_nxt      (off_nxt),
		.line_nxt     (line_nxt),
		.col_nxt      (col_nxt),
		.n_res        (n_res),
		.res          (res)
	);

	// room for three new results whatever the output side does this cycle
	assign s_tready = (cnt_q <= CW'(FIFO_DEPTH - MAX_RES));
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = (cnt_q != '0);
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_NONE;
			off_q  <= '0;
			line_q <= '0;
			col_q  <= '0;
		end else if (acc) begin
			pend_q <= pend_nxt;
			off_q  <= off_nxt;
			line_q <= line_nxt;
			col_q  <= col_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (pop)
				rd_q <= rd_q + PW'(1);
			if (acc)
				wr_q <= wr_q + PW'(n_res);
			cnt_q <= cnt_q + (acc ? CW'(n_res) : CW'(0)) - (pop ? CW'(1) : CW'(0));
		end
	end

	// queue payload, no reset
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int k = 0; k < MAX_RES; k++) begin
				if (2'(k) < n_res)
					fifo_q[wr_q + PW'(k)] <= res[k];
			end
		end
	end

	assign head    = fifo_q[rd_q];
	assign m_tdata = {head.column, head.line_number, head.byte_offset, head.char_value};
	assign m_tuser = head.is_end;
	assign m_tlast = head.last;

	`LSNN_ASSERT(a_cnt_bound, cnt_q <= CW'(FIFO_DEPTH), "result queue overfilled")
	`LSNN_ASSERT(a_ptr_sync, PW'(rd_q + cnt_q[PW-1:0]) == wr_q, "queue pointers disagree")
	`LSNN_ASSERT(a_end_last, !(m_tvalid && m_tuser) || m_tlast, "end marker not last")
	`LSNN_ASSERT_NEXT(a_eos_clear, acc && s_tlast, pend_q == PEND_NONE, "lookahead kept over end")

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for line_splice_newline_normalizer.
// Directed table plus random text streams, checked against a predictor of the
// splice / CR LF folding rules. Depends on lsnn_pkg and the top-level RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lsnn_pkg::*;

	// One row of stimulus. When typed is set the single result of the byte is
	// written out here (char = byte_value, last = 1); otherwise the predictor
	// supplies the expected results.
	typedef struct packed {
		logic [7:0]  byte_value;
		logic        eos;
		logic        typed;
		logic [31:0] w_off;
		logic [31:0] w_line;
		logic [31:0] w_col;
	} row_t;

	localparam int N_RANDOM = 450;
	localparam int HOLD_AT  = 150;   // accepted bytes before the long sink hold-off
	localparam int HOLD_LEN = 80;    // cycles of the hold-off
	localparam int TAIL     = 20;    // quiet cycles after the last result

	// Directed part: plain extremes after reset, both splice forms, CR LF,
	// lone CR, backslash CR followed by a non-LF byte (three results), and
	// end of stream with each kind of lookahead held.
	localparam row_t DIRECTED [27] = '{
		'{8'h41, 1'b0, 1'b1, 32'd1, 32'd0, 32'd1},
		'{8'h00, 1'b0, 1'b1, 32'd2, 32'd0, 32'd2},
		'{8'hff, 1'b0, 1'b1, 32'd3, 32'd0, 32'd3},
		'{8'h0a, 1'b0, 1'b1, 32'd4, 32'd1, 32'd0},
		'{8'h5c, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h0a, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h5c, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h0d, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h0a, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h0d, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h0a, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h0d, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h5c, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h0d, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h5c, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h5c, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h0d, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h7a, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h0d, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h0d, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'hff, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h5c, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h0d, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h5c, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h5c, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h00, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0},
		'{8'h00, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0}
	};

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata  = 8'h00;   // [7:0] byte_value
	logic         s_tlast  = 1'b0;    // end_of_stream
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;            // [7:0] char, [39:8] offset, [71:40] line, [103:72] column
	logic         m_tuser;            // [0] is_end
	logic         m_tlast;            // last result of the byte

	// Predictor state.
	pend_t       la_kind   = PEND_NONE;
	logic [31:0] ck_off    = '0;
	logic [31:0] ck_line   = '0;
	logic [31:0] ck_col    = '0;
	result_t     fresh[$];            // results of the byte being predicted
	result_t     due_chars[$];        // expected results not yet seen

	row_t stim_q[$];
	int   cur_idx = 0;                // row currently offered by the driver
	int   n_in = 0, n_out = 0, n_end = 0, n_splice = 0, n_crlf = 0, n_triple = 0;
	int   errs = 0;

	line_splice_newline_normalizer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// A character that takes one raw byte; LF is a newline.
	function automatic void put_char(input logic [7:0] c);
		ck_off = ck_off + 32'd1;
		if (c == CH_LF) begin
			ck_line = ck_line + 32'd1;
			ck_col  = '0;
		end else begin
			ck_col = ck_col + 32'd1;
		end
		fresh.push_back({1'b0, 1'b0, ck_col, ck_line, ck_off, c});
	endfunction

	// Fresh look at a byte with nothing held.
	function automatic void scan_byte(input logic [7:0] b);
		if (b == CH_BACKSLASH)
			la_kind = PEND_BS;
		else if (b == CH_CR)
			la_kind = PEND_CR;
		else
			put_char(b);
	endfunction

	// Backslash-newline removed: no character, but the position moves on.
	function automatic void join_lines(input int len);
		ck_off  = ck_off + len;
		ck_line = ck_line + 32'd1;
		ck_col  = '0;
		la_kind = PEND_NONE;
		n_splice++;
	endfunction

	function automatic void normalize_byte(input logic [7:0] b, input logic eos);
		pend_t held;
		held = la_kind;
		fresh.delete();
		if (eos) begin
			// flush whatever lookahead is held, then the end marker
			la_kind = PEND_NONE;
			case (held)
				PEND_BS:   put_char(CH_BACKSLASH);
				PEND_BSCR: begin
					put_char(CH_BACKSLASH);
					put_char(CH_CR);
				end
				PEND_CR:   put_char(CH_CR);
				default:   ;
			endcase
			fresh.push_back({1'b0, 1'b1, ck_col, ck_line, ck_off, 8'h00});
		end else begin
			case (held)
				PEND_NONE: scan_byte(b);
				PEND_BS: begin
					if (b == CH_LF)
						join_lines(2);
					else if (b == CH_CR)
						la_kind = PEND_BSCR;
					else begin
						la_kind = PEND_NONE;
						put_char(CH_BACKSLASH);
						scan_byte(b);
					end
				end
				PEND_BSCR: begin
					if (b == CH_LF)
						join_lines(3);
					else begin
						la_kind = PEND_NONE;
						put_char(CH_BACKSLASH);
						put_char(CH_CR);
						scan_byte(b);
					end
				end
				default: begin
					// CR held: CR LF folds to one LF over two bytes
					la_kind = PEND_NONE;
					if (b == CH_LF) begin
						ck_off  = ck_off + 32'd2;
						ck_line = ck_line + 32'd1;
						ck_col  = '0;
						fresh.push_back({1'b0, 1'b0, ck_col, ck_line, ck_off, CH_LF});
						n_crlf++;
					end else begin
						put_char(CH_CR);
						scan_byte(b);
					end
				end
			endcase
		end
		if (fresh.size() > 0)
			fresh[fresh.size() - 1].last = 1'b1;
		if (fresh.size() == 3)
			n_triple++;
	endfunction

	// ---------------------------------------------------------------------
	// Scoreboard
	// ---------------------------------------------------------------------

	// Printing stops after a few dozen lines; counting goes on.
	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (errs < 40)
			$display("%0t ns result %0d %s: got 0x%0h want 0x%0h", $time, n_out, what, got, want);
		errs++;
	endtask

	// Input transactions are predicted before output transactions are
	// checked, so even a same-cycle result would find its expectation queued.
	// Both sides are sampled at the rising edge, before the RTL updates.
	always @(posedge clk) begin : scoreboard
		result_t got;
		result_t want;
		row_t    r;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				r = stim_q[cur_idx];
				normalize_byte(s_tdata, s_tlast);
				n_in++;
				if (r.typed)
					due_chars.push_back({1'b1, 1'b0, r.w_col, r.w_line, r.w_off, r.byte_value});
				else
					foreach (fresh[k]) due_chars.push_back(fresh[k]);
			end
			if (m_tvalid && m_tready) begin
				got = {m_tlast, m_tuser, m_tdata[103:72], m_tdata[71:40],
				       m_tdata[39:8], m_tdata[7:0]};
				n_out++;
				if (got.is_end)
					n_end++;
				if (due_chars.size() == 0) begin
					report_mismatch("result with nothing due", got.char_value, 0);
				end else begin
					want = due_chars.pop_front();
					if (got.char_value !== want.char_value)
						report_mismatch("char_value", got.char_value, want.char_value);
					if (got.is_end !== want.is_end)
						report_mismatch("is_end", got.is_end, want.is_end);
					if (got.byte_offset !== want.byte_offset)
						report_mismatch("byte_offset", got.byte_offset, want.byte_offset);
					if (got.line_number !== want.line_number)
						report_mismatch("line_number", got.line_number, want.line_number);
					if (got.column !== want.column)
						report_mismatch("column", got.column, want.column);
					if (got.last !== want.last)
						report_mismatch("last", got.last, want.last);
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Sink: m_tready pattern changes mode at random intervals (always
	// ready, coin flip, mostly ready, mostly stalled). Once, after HOLD_AT
	// bytes, it holds off long enough for the result queue to fill and
	// s_tready to drop while the driver keeps offering.
	// ---------------------------------------------------------------------
	initial begin : sink
		int  mode;
		int  mode_left;
		bit  held_once;
		mode      = 0;
		mode_left = 0;
		held_once = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_once && n_in >= HOLD_AT) begin
				held_once = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(8, 40);
			end
			mode_left--;
			case (mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				2:       m_tready <= ($urandom_range(0, 7) != 0);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus and end of run
	// ---------------------------------------------------------------------
	initial begin : main
		int          left;
		int          gap;
		int          n_dir;
		int          mid_drain;
		int          pick;
		logic [7:0]  rb;
		left = 0;
		n_dir = $size(DIRECTED);
		mid_drain = n_dir + N_RANDOM / 2;

		foreach (DIRECTED[k]) stim_q.push_back(DIRECTED[k]);

		// Random part: mostly well-formed splices, CR LF pairs and text, with
		// broken lookaheads and stray end-of-stream markers mixed in.
		while (stim_q.size() < n_dir + N_RANDOM) begin
			pick = $urandom_range(0, 19);
			rb   = 8'($urandom_range(0, 255));
			case (pick)
				0, 1, 2, 3, 4, 5: stim_q.push_back({rb, 1'b0, 1'b0, 96'd0});
				6, 7: stim_q.push_back({8'($urandom_range(8'h20, 8'h7e)), 1'b0, 1'b0, 96'd0});
				8: begin
					stim_q.push_back({CH_BACKSLASH, 1'b0, 1'b0, 96'd0});
					stim_q.push_back({CH_LF, 1'b0, 1'b0, 96'd0});
				end
				9: begin
					stim_q.push_back({CH_BACKSLASH, 1'b0, 1'b0, 96'd0});
					stim_q.push_back({CH_CR, 1'b0, 1'b0, 96'd0});
					stim_q.push_back({CH_LF, 1'b0, 1'b0, 96'd0});
				end
				10, 11: begin
					stim_q.push_back({CH_CR, 1'b0, 1'b0, 96'd0});
					stim_q.push_back({CH_LF, 1'b0, 1'b0, 96'd0});
				end
				12: begin
					stim_q.push_back({CH_CR, 1'b0, 1'b0, 96'd0});
					stim_q.push_back({rb, 1'b0, 1'b0, 96'd0});
				end
				13: begin
					stim_q.push_back({CH_BACKSLASH, 1'b0, 1'b0, 96'd0});
					stim_q.push_back({rb, 1'b0, 1'b0, 96'd0});
				end
				14: begin
					stim_q.push_back({CH_BACKSLASH, 1'b0, 1'b0, 96'd0});
					stim_q.push_back({CH_CR, 1'b0, 1'b0, 96'd0});
					stim_q.push_back({rb, 1'b0, 1'b0, 96'd0});
				end
				15: stim_q.push_back({CH_LF, 1'b0, 1'b0, 96'd0});
				16, 17: begin
					case ($urandom_range(0, 2))
						0:       stim_q.push_back({CH_BACKSLASH, 1'b0, 1'b0, 96'd0});
						1:       stim_q.push_back({CH_CR, 1'b0, 1'b0, 96'd0});
						default: stim_q.push_back({CH_LF, 1'b0, 1'b0, 96'd0});
					endcase
				end
				18: stim_q.push_back({rb, 1'b1, 1'b0, 96'd0});
				default: stim_q.push_back({rb, 1'b0, 1'b0, 96'd0});
			endcase
		end
		// close the stream so any lookahead is flushed
		stim_q.push_back({8'($urandom_range(0, 255)), 1'b1, 1'b0, 96'd0});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Driver: bursts of random length with random gaps; at the start of
		// the random part and once in its middle it waits for every expected
		// result before going on.
		for (int i = 0; i < stim_q.size(); i++) begin
			if (left == 0 || i == n_dir || i == mid_drain) begin
				if (left == 0)
					left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				if ((i == n_dir || i == mid_drain) && gap == 0)
					gap = 1;
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				if (i == n_dir || i == mid_drain)
					while (due_chars.size() != 0) @(negedge clk);
			end
			cur_idx = i;
			s_tvalid <= 1'b1;
			s_tdata  <= stim_q[i].byte_value;
			s_tlast  <= stim_q[i].eos;
			do @(posedge clk); while (!s_tready);
			left--;
			@(negedge clk);
		end
		s_tvalid <= 1'b0;

		// Wait for the last results, then stay a while so a stray extra
		// transaction would still be caught by the scoreboard.
		while (due_chars.size() != 0) @(negedge clk);
		repeat (TAIL) @(negedge clk);

		$display("Ran %0d input bytes (%0d end markers) and checked %0d results.",
		         n_in, n_end, n_out);
		$display("Seen: %0d line splices, %0d CR LF folds, %0d bytes giving three results.",
		         n_splice, n_crlf, n_triple);
		if (errs == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errs);
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog: the whole run needs well under a millisecond.
	initial begin : watchdog
		#5_000_000;
		$display("timeout with %0d results still due", due_chars.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/lsnn_pkg.sv
src/lsnn_decode.sv
src/line_splice_newline_normalizer.sv
verif/tb.sv
